// File: rtl/dcfp_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and codes for the drive command frame parser
package dcfp_pkg;

    localparam int HEADER_LEN      = 6;
    localparam int DRIVE_LEN       = 6;
    localparam int COUNT_W         = 9;
    localparam int CFG_IDX_W       = 3;
    localparam int SEQ_VALID_COUNT = 5;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // header byte positions
    localparam logic [COUNT_W-1:0] POS_MAGIC_FIRST  = 9'd0;
    localparam logic [COUNT_W-1:0] POS_MAGIC_SECOND = 9'd1;
    localparam logic [COUNT_W-1:0] POS_VERSION      = 9'd2;
    localparam logic [COUNT_W-1:0] POS_MSG_TYPE     = 9'd3;
    localparam logic [COUNT_W-1:0] POS_SEQUENCE     = 9'd4;
    localparam logic [COUNT_W-1:0] POS_PAYLOAD_LEN  = 9'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_FIRST       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_SECOND      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VERSION_BYTE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COMMAND_TYPE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_RECORD_TYPE = 3'd4;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_SHORT        = 3'd1,
        ST_MAGIC        = 3'd2,
        ST_VERSION      = 3'd3,
        ST_TYPE         = 3'd4,
        ST_PAYLOAD_LONG = 3'd5,
        ST_OVERRUN      = 3'd6,
        ST_DRIVE_LEN    = 3'd7
    } status_t;

    typedef enum logic [1:0] {
        PH_TYPE  = 2'd0,
        PH_LEN   = 2'd1,
        PH_VALUE = 2'd2
    } record_phase_t;

    typedef struct packed {
        logic [7:0] magic_first;
        logic [7:0] magic_second;
        logic [7:0] version_byte;
        logic [7:0] command_type;
        logic [7:0] drive_record_type;
    } cfg_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_end;
    } in_item_t;

    typedef struct packed {
        status_t            status;
        logic [7:0]         sequence_res;
        logic               drive_ok;
        logic signed [15:0] vel_x;
        logic signed [15:0] vel_y;
        logic signed [15:0] turn_rate;
    } out_item_t;

endpackage

// File: rtl/dcfp_cfg_regs.sv
`timescale 1ns / 1ps
// configuration register file of the frame parser
module dcfp_cfg_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          wr_en,
    input  logic [dcfp_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [7:0]                    wr_data,
    output dcfp_pkg::cfg_t                cfg
);
    import dcfp_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (wr_index)
                CFG_MAGIC_FIRST:       cfg_next.magic_first       = wr_data;
                CFG_MAGIC_SECOND:      cfg_next.magic_second      = wr_data;
                CFG_VERSION_BYTE:      cfg_next.version_byte      = wr_data;
                CFG_COMMAND_TYPE:      cfg_next.command_type      = wr_data;
                CFG_DRIVE_RECORD_TYPE: cfg_next.drive_record_type = wr_data;
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/dcfp_parser.sv
`timescale 1ns / 1ps
// per-byte header check, record walk and frame-end status computation
module dcfp_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  dcfp_pkg::cfg_t      cfg,
    input  logic                in_accept,
    input  dcfp_pkg::in_item_t  in_item,
    output logic                res_valid,
    output dcfp_pkg::out_item_t res_item
);
    import dcfp_pkg::*;

    logic [COUNT_W-1:0] byte_count_reg, byte_count_next, byte_count_upd;
    logic [7:0]         payload_length_reg, payload_length_next, payload_length_upd;
    logic [7:0]         seq_hold_reg, seq_hold_next, seq_hold_upd;
    status_t            header_error_reg, header_error_next, header_error_upd;
    status_t            record_error_reg, record_error_next, record_error_upd;
    record_phase_t      record_phase_reg, record_phase_next, record_phase_upd;
    logic [7:0]         record_type_hold_reg, record_type_hold_next, record_type_hold_upd;
    logic [7:0]         record_remaining_reg, record_remaining_next, record_remaining_upd;
    logic [47:0]        drive_staging_reg, drive_staging_next, drive_staging_upd;
    logic               drive_found_reg, drive_found_next, drive_found_upd;
    logic [47:0]        drive_values_reg, drive_values_next, drive_values_upd;

    logic [7:0]         b;
    logic [COUNT_W-1:0] idx;
    logic               in_payload;
    logic               is_drive;
    logic [2:0]         lane;
    logic [7:0]         remaining_dec;
    status_t            status;
    logic               ok;

    assign b          = in_item.data_byte;
    assign idx        = byte_count_reg - COUNT_W'(HEADER_LEN);
    assign in_payload = (byte_count_reg >= COUNT_W'(HEADER_LEN)) &&
                        (idx < {1'b0, payload_length_reg});
    assign is_drive   = (record_type_hold_reg == cfg.drive_record_type);
    assign lane       = 3'(DRIVE_LEN) - record_remaining_reg[2:0];
    assign remaining_dec = record_remaining_reg - 8'd1;

    // one byte step
    always_comb begin
        byte_count_upd       = byte_count_reg;
        payload_length_upd   = payload_length_reg;
        seq_hold_upd         = seq_hold_reg;
        header_error_upd     = header_error_reg;
        record_error_upd     = record_error_reg;
        record_phase_upd     = record_phase_reg;
        record_type_hold_upd = record_type_hold_reg;
        record_remaining_upd = record_remaining_reg;
        drive_staging_upd    = drive_staging_reg;
        drive_found_upd      = drive_found_reg;
        drive_values_upd     = drive_values_reg;

        if (byte_count_reg == POS_MAGIC_FIRST) begin
            if (b != cfg.magic_first && header_error_reg == ST_OK) begin
                header_error_upd = ST_MAGIC;
            end
        end else if (byte_count_reg == POS_MAGIC_SECOND) begin
            if (b != cfg.magic_second && header_error_reg == ST_OK) begin
                header_error_upd = ST_MAGIC;
            end
        end else if (byte_count_reg == POS_VERSION) begin
            if (b != cfg.version_byte && header_error_reg == ST_OK) begin
                header_error_upd = ST_VERSION;
            end
        end else if (byte_count_reg == POS_MSG_TYPE) begin
            if (b != cfg.command_type && header_error_reg == ST_OK) begin
                header_error_upd = ST_TYPE;
            end
        end else if (byte_count_reg == POS_SEQUENCE) begin
            seq_hold_upd = b;
        end else if (byte_count_reg == POS_PAYLOAD_LEN) begin
            payload_length_upd = b;
        end else if (in_payload && record_error_reg == ST_OK) begin
            case (record_phase_reg)
                PH_TYPE: begin
                    // a lone trailing byte cannot start a record
                    if (({1'b0, idx} + 10'd2) <= {2'b00, payload_length_reg}) begin
                        record_type_hold_upd = b;
                        record_phase_upd     = PH_LEN;
                    end
                end
                PH_LEN: begin
                    if (({1'b0, idx} + 10'd1 + {2'b00, b}) > {2'b00, payload_length_reg}) begin
                        record_error_upd = ST_OVERRUN;
                    end else if (is_drive && b != 8'(DRIVE_LEN)) begin
                        record_error_upd = ST_DRIVE_LEN;
                    end else if (b == 8'd0) begin
                        record_phase_upd = PH_TYPE;
                    end else begin
                        record_remaining_upd = b;
                        drive_staging_upd    = '0;
                        record_phase_upd     = PH_VALUE;
                    end
                end
                default: begin
                    if (is_drive) begin
                        for (int i = 0; i < DRIVE_LEN; i++) begin
                            if (lane == 3'(i)) begin
                                drive_staging_upd[i*8 +: 8] = drive_staging_reg[i*8 +: 8] | b;
                            end
                        end
                    end
                    record_remaining_upd = remaining_dec;
                    if (remaining_dec == 8'd0) begin
                        if (is_drive) begin
                            drive_values_upd = drive_staging_upd;
                            drive_found_upd  = 1'b1;
                        end
                        record_phase_upd = PH_TYPE;
                    end
                end
            endcase
        end

        if (byte_count_reg != COUNT_MAX) begin
            byte_count_upd = byte_count_reg + COUNT_W'(1);
        end
    end

    // frame-end status from the updated state
    always_comb begin
        if (byte_count_upd < COUNT_W'(HEADER_LEN)) begin
            status = ST_SHORT;
        end else if (header_error_upd != ST_OK) begin
            status = header_error_upd;
        end else if ({1'b0, payload_length_upd} > (byte_count_upd - COUNT_W'(HEADER_LEN))) begin
            status = ST_PAYLOAD_LONG;
        end else begin
            status = record_error_upd;
        end
        ok = (status == ST_OK) && drive_found_upd;

        res_item.status       = status;
        res_item.sequence_res = (byte_count_upd >= COUNT_W'(SEQ_VALID_COUNT)) ?
                                seq_hold_upd : 8'd0;
        res_item.drive_ok     = ok;
        res_item.vel_x        = ok ? signed'(drive_values_upd[15:0])  : 16'sd0;
        res_item.vel_y        = ok ? signed'(drive_values_upd[31:16]) : 16'sd0;
        res_item.turn_rate    = ok ? signed'(drive_values_upd[47:32]) : 16'sd0;
    end

    assign res_valid = in_accept && in_item.frame_end;

    always_comb begin
        byte_count_next       = byte_count_reg;
        payload_length_next   = payload_length_reg;
        seq_hold_next         = seq_hold_reg;
        header_error_next     = header_error_reg;
        record_error_next     = record_error_reg;
        record_phase_next     = record_phase_reg;
        record_type_hold_next = record_type_hold_reg;
        record_remaining_next = record_remaining_reg;
        drive_staging_next    = drive_staging_reg;
        drive_found_next      = drive_found_reg;
        drive_values_next     = drive_values_reg;
        if (in_accept) begin
            if (in_item.frame_end) begin
                byte_count_next       = '0;
                payload_length_next   = '0;
                seq_hold_next         = '0;
                header_error_next     = ST_OK;
                record_error_next     = ST_OK;
                record_phase_next     = PH_TYPE;
                record_type_hold_next = '0;
                record_remaining_next = '0;
                drive_staging_next    = '0;
                drive_found_next      = 1'b0;
                drive_values_next     = '0;
            end else begin
                byte_count_next       = byte_count_upd;
                payload_length_next   = payload_length_upd;
                seq_hold_next         = seq_hold_upd;
                header_error_next     = header_error_upd;
                record_error_next     = record_error_upd;
                record_phase_next     = record_phase_upd;
                record_type_hold_next = record_type_hold_upd;
                record_remaining_next = record_remaining_upd;
                drive_staging_next    = drive_staging_upd;
                drive_found_next      = drive_found_upd;
                drive_values_next     = drive_values_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg       <= '0;
            payload_length_reg   <= '0;
            seq_hold_reg         <= '0;
            header_error_reg     <= ST_OK;
            record_error_reg     <= ST_OK;
            record_phase_reg     <= PH_TYPE;
            record_type_hold_reg <= '0;
            record_remaining_reg <= '0;
            drive_staging_reg    <= '0;
            drive_found_reg      <= 1'b0;
            drive_values_reg     <= '0;
        end else begin
            byte_count_reg       <= byte_count_next;
            payload_length_reg   <= payload_length_next;
            seq_hold_reg         <= seq_hold_next;
            header_error_reg     <= header_error_next;
            record_error_reg     <= record_error_next;
            record_phase_reg     <= record_phase_next;
            record_type_hold_reg <= record_type_hold_next;
            record_remaining_reg <= record_remaining_next;
            drive_staging_reg    <= drive_staging_next;
            drive_found_reg      <= drive_found_next;
            drive_values_reg     <= drive_values_next;
        end
    end

    // frame end restarts the byte counter
    a_count_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept && in_item.frame_end |=> byte_count_reg == '0)
        else $error("byte counter not cleared after frame end");

    // a record error sticks for the rest of the frame
    a_record_error_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept && !in_item.frame_end && record_error_reg != ST_OK
        |=> record_error_reg == $past(record_error_reg))
        else $error("record error changed inside a frame");

    // header errors only come from the first four bytes
    a_header_error_window: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept && !in_item.frame_end && byte_count_reg > POS_MSG_TYPE
        |=> header_error_reg == $past(header_error_reg))
        else $error("header error set past the check bytes");

endmodule

// File: rtl/dcfp_out_reg.sv
`timescale 1ns / 1ps
// result register between the parser and the result channel
module dcfp_out_reg (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  dcfp_pkg::out_item_t load_item,
    output logic                can_load,
    output logic                m_valid,
    input  logic                m_ready,
    output dcfp_pkg::out_item_t m_payload
);
    import dcfp_pkg::*;

    logic      m_valid_reg, m_valid_next;
    out_item_t m_payload_reg, m_payload_next;

    assign can_load = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next   = m_valid_reg;
        m_payload_next = m_payload_reg;
        if (load) begin
            m_valid_next   = 1'b1;
            m_payload_next = load_item;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_payload_reg <= m_payload_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // a new result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        load && m_valid_reg |-> m_ready)
        else $error("result register overwritten while stalled");

    // a drive is reported only with a good status
    a_drive_needs_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_payload_reg.drive_ok |-> m_payload_reg.status == ST_OK)
        else $error("drive flagged on a failed frame");

    // without a drive all velocities are zero
    a_zero_velocity: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_payload_reg.drive_ok
        |-> m_payload_reg.vel_x == 16'sd0 && m_payload_reg.vel_y == 16'sd0 &&
            m_payload_reg.turn_rate == 16'sd0)
        else $error("nonzero velocity without a drive record");

endmodule

// File: rtl/drive_command_frame_parser.sv
`timescale 1ns / 1ps
// top level of the drive command frame parser
//
// takes a command frame one byte per input transaction, frame_end set on the
// final byte, and returns one result transaction per frame. the header
// check, the record walk and, on the final byte, the status priority are all
// worked out from the parser state registers and the incoming byte, so a new
// byte can be accepted every clock, but for the frame-end hold-off below.
// results land in a one-entry output register; bytes that do not end a frame
// keep flowing while a result waits, and a frame-end byte is held off only
// while the output register is full and not being drained. the result comes
// out the cycle after its final byte is accepted. status priority is short
// frame, then the first header mismatch, then payload past the frame end,
// then the first record error; velocities and the drive flag read zero unless
// the status is ok. configuration writes are always ready, and must only
// happen while no frame is in progress. indexes past the last register are
// dropped.
module drive_command_frame_parser (
    input  logic                           aclk,
    input  logic                           aresetn,

    // configuration write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [dcfp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                     cfg_data,

    // byte input channel
    input  logic                           s_valid,
    output logic                           s_ready,
    input  dcfp_pkg::in_item_t             s_payload,

    // result channel
    output logic                           m_valid,
    input  logic                           m_ready,
    output dcfp_pkg::out_item_t            m_payload
);
    import dcfp_pkg::*;

    cfg_t      cfg;
    logic      in_accept;
    logic      res_valid;
    out_item_t res_item;
    logic      can_load;

    // register writes never stall
    assign cfg_ready = 1'b1;

    dcfp_cfg_regs u_cfg_regs (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // only a frame-end byte needs room in the output register
    assign s_ready   = can_load || !s_payload.frame_end;
    assign in_accept = s_valid && s_ready;

    dcfp_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_accept (in_accept),
        .in_item   (s_payload),
        .res_valid (res_valid),
        .res_item  (res_item)
    );

    dcfp_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (res_valid),
        .load_item (res_item),
        .can_load  (can_load),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule
